// ----- hw/rtl/poc_pkg.sv -----
// Package: shared constants and types for the path clearance block.
`default_nettype none
package poc_pkg;
  localparam int MaxObstacles = 4096;
  localparam int ObsAw        = $clog2(MaxObstacles);
  localparam int CntW         = $clog2(MaxObstacles + 1);
  localparam int MaxGridDim   = 4096;
  localparam int DimW         = $clog2(MaxGridDim);
  localparam int MaxPathPts   = 4096;
  localparam int PtsW         = $clog2(MaxPathPts + 1);
  localparam int SumW         = 32 + PtsW;
  localparam int CfgW         = 32;

  localparam logic [2:0] RegGridWidth = 3'd0;
  localparam logic [2:0] RegCellSize  = 3'd1;
  localparam logic [2:0] RegOriginX   = 3'd2;
  localparam logic [2:0] RegOriginY   = 3'd3;
  localparam logic [2:0] RegOccMark   = 3'd4;

  typedef struct packed {
    logic [DimW-1:0] col;
    logic [DimW-1:0] row;
  } obs_t;
endpackage
`default_nettype wire

// ----- hw/rtl/poc_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module poc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/path_obstacle_clearance.sv -----
// Top level: obstacle grid loader and nearest-obstacle path clearance engine.
// A load leaves busy low, so loads may follow every cycle while no query is running.
// A query holds busy as it walks each obstacle (read, two scaled coordinates, two
// squares, compare) on one shared 32x32 multiplier, ends the walk, takes the square
// root and a divider step and registers the result; last point runs the full divide.
// out_valid strobes the result for one cycle as busy falls; the receiver cannot stall.
// Synchronous active-low reset clears counters, sums and config to defaults;
// the obstacle memory is not cleared (the fill count bounds all reads).
`default_nettype none
module path_obstacle_clearance (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic        in_first_cell,
  input  wire logic signed [7:0]  in_cell_value,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic        in_last_point,
  output logic             out_valid,
  output logic [31:0]      out_min_distance,
  output logic [31:0]      out_mean_clearance,
  output logic             out_is_last,
  output logic             out_no_obstacle,
  output logic             out_store_overflow,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [poc_pkg::CfgW-1:0] cfg_data
);
  import poc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_RD   = 11'b00000000010,
    S_MX   = 11'b00000000100,
    S_MY   = 11'b00000001000,
    S_SX   = 11'b00000010000,
    S_SY   = 11'b00000100000,
    S_CMP  = 11'b00001000000,
    S_SQ   = 11'b00010000000,
    S_DIV  = 11'b00100000000,
    S_OUT  = 11'b01000000000,
    S_LOAD = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [12:0] grid_width_r;
  logic [16:0] cell_size_r;
  logic [31:0] origin_x_r, origin_y_r;
  logic [6:0]  occ_mark_r;

  logic [CntW-1:0] count_r;
  logic            dropped_r;
  logic [DimW-1:0] col_r, row_r;
  logic [SumW-1:0] sum_r;
  logic [PtsW-1:0] pts_r;

  logic signed [31:0] px_r, py_r;
  logic        last_r;
  logic [CntW-1:0] k_r;
  obs_t        obs_rd;
  logic [63:0] prod_r;
  logic [63:0] sx_r, best_r;
  logic [31:0] mag_r;

  // root state
  logic [63:0] rem_r;
  logic [31:0] root_r;
  logic [5:0]  it_r;
  // divider state
  logic [SumW-1:0] quo_r;
  logic [PtsW:0]   drem_r;
  logic [31:0]     dist_r;

  logic        load_fire;
  logic        mem_we;
  obs_t        mem_wd;
  logic [12:0] width_eff;

  logic [CntW-1:0] cnt_base;
  logic [DimW-1:0] cb, rb;

  assign busy      = (state_r != S_IDLE);
  assign load_fire = start && !busy && !in_cmd;

  always_comb begin
    width_eff = grid_width_r;
    if (width_eff == 13'd0) width_eff = 13'd1;
    if (width_eff > 13'(MaxGridDim)) width_eff = 13'(MaxGridDim);
  end

  poc_ram #(.Width($bits(obs_t)), .Depth(MaxObstacles)) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(cnt_base[ObsAw-1:0]),
    .wdata(mem_wd),
    .raddr(k_r[ObsAw-1:0]),
    .rdata(obs_rd)
  );

  // one shared multiplier: coordinate times cell size, then magnitude squared
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;
  always_comb begin
    mul_a = 32'(obs_rd.col);
    mul_b = 32'(cell_size_r);
    case (state_r)
      S_MY:    mul_a = 32'(obs_rd.row);
      S_SX,
      S_SY:    begin mul_a = mag_r; mul_b = mag_r; end
      default: ;
    endcase
  end

  // offset and clamp of the product sitting in prod_r
  logic signed [34:0] off_c;
  logic [34:0]        abs_c;
  logic [31:0]        mag_c;
  always_comb begin
    if (state_r == S_MY)
      off_c = 35'(px_r) - 35'(prod_r[31:0]) - 35'(signed'(origin_x_r));
    else
      off_c = 35'(py_r) - 35'(prod_r[31:0]) - 35'(signed'(origin_y_r));
    abs_c = off_c[34] ? 35'(-off_c) : off_c;
    mag_c = (abs_c[34:32] != 3'd0) ? 32'hFFFF_FFFF : abs_c[31:0];
  end

  logic [64:0] ssum;
  assign ssum = 65'(sx_r) + 65'(mul_p);

  logic [65:0] rem_sh, cand;
  always_comb begin
    rem_sh = {rem_r[63:0], 2'b00} | 66'(best_r[63:62]);
    cand   = 66'({root_r, 2'b01});
  end

  logic [PtsW:0] dr_sh;
  assign dr_sh = {drem_r[PtsW-1:0], quo_r[SumW-1]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = in_cmd ? S_RD : S_IDLE;
      S_RD:   state_nxt = (k_r < count_r) ? S_MX : S_SQ;
      S_MX:   state_nxt = S_MY;
      S_MY:   state_nxt = S_SX;
      S_SX:   state_nxt = S_SY;
      S_SY:   state_nxt = S_CMP;
      S_CMP:  state_nxt = S_RD;
      S_SQ:   if (it_r == 6'd31) state_nxt = S_DIV;
      S_DIV:  if (!last_r || it_r == 6'(SumW - 1)) state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wd.col = in_first_cell ? '0 : col_r;
    mem_wd.row = in_first_cell ? '0 : row_r;
    if (load_fire && in_cell_value == signed'({1'b0, occ_mark_r})
        && (in_first_cell || count_r < CntW'(MaxObstacles)))
      mem_we = 1'b1;
  end

  always_comb begin
    cnt_base = in_first_cell ? '0 : count_r;
    cb = in_first_cell ? '0 : col_r;
    rb = in_first_cell ? '0 : row_r;
  end

  logic [SumW-1:0] sum_add;
  logic [PtsW-1:0] pts_add;
  always_comb begin
    sum_add = sum_r;
    pts_add = pts_r;
    if (pts_r < PtsW'(MaxPathPts)) begin
      sum_add = sum_r + SumW'(dist_r);
      pts_add = pts_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      grid_width_r <= 13'd4096;
      cell_size_r <= 17'd3277;
      origin_x_r <= '0;
      origin_y_r <= '0;
      occ_mark_r <= 7'd100;
      count_r <= '0;
      dropped_r <= 1'b0;
      col_r <= '0;
      row_r <= '0;
      sum_r <= '0;
      pts_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          RegGridWidth: grid_width_r <= cfg_data[12:0];
          RegCellSize:  cell_size_r  <= cfg_data[16:0];
          RegOriginX:   origin_x_r   <= cfg_data[31:0];
          RegOriginY:   origin_y_r   <= cfg_data[31:0];
          RegOccMark:   occ_mark_r   <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (load_fire) begin
        count_r <= cnt_base + CntW'(mem_we);
        if (in_first_cell) dropped_r <= 1'b0;
        if (!mem_we && in_cell_value == signed'({1'b0, occ_mark_r}))
          dropped_r <= 1'b1;
        if (13'(cb) + 13'd1 >= width_eff) begin
          col_r <= '0;
          row_r <= rb + 1'b1;
        end else begin
          col_r <= cb + 1'b1;
          row_r <= rb;
        end
      end
      if (state_r == S_OUT) begin
        out_valid <= 1'b1;
        if (last_r) begin
          sum_r <= '0;
          pts_r <= '0;
        end else begin
          sum_r <= sum_add;
          pts_r <= pts_add;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        px_r <= in_point_x;
        py_r <= in_point_y;
        last_r <= in_last_point;
        k_r <= '0;
        best_r <= '1;
      end
      S_MX:  prod_r <= mul_p;
      S_MY:  begin mag_r <= mag_c; prod_r <= mul_p; end
      S_SX:  begin sx_r <= mul_p; mag_r <= mag_c; end
      S_SY:  begin
        if (ssum[64]) sx_r <= '1; else sx_r <= ssum[63:0];
      end
      S_CMP: begin
        if (sx_r < best_r) best_r <= sx_r;
        k_r <= k_r + 1'b1;
      end
      S_RD: begin
        rem_r <= '0;
        root_r <= '0;
        it_r <= '0;
        if (count_r == '0) best_r <= '0;
      end
      S_SQ: begin
        // restoring root: two radicand bits per step
        if (rem_sh >= cand) begin
          rem_r  <= 64'(rem_sh - cand);
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[63:0];
          root_r <= {root_r[30:0], 1'b0};
        end
        best_r <= {best_r[61:0], 2'b00};
        if (it_r == 6'd31) begin
          it_r <= '0;
          drem_r <= '0;
        end else it_r <= it_r + 1'b1;
        if (it_r == 6'd31) dist_r <= {root_r[30:0], (rem_sh >= cand)};
      end
      S_DIV: begin
        it_r <= it_r + 1'b1;
        if (dr_sh >= {1'b0, pts_add}) begin
          drem_r <= dr_sh - {1'b0, pts_add};
          quo_r <= {quo_r[SumW-2:0], 1'b1};
        end else begin
          drem_r <= dr_sh;
          quo_r <= {quo_r[SumW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (state_r == S_SQ && it_r == 6'd31)
      quo_r <= sum_r + SumW'({root_r[30:0], (rem_sh >= cand)}) &
               {SumW{pts_r < PtsW'(MaxPathPts)}} |
               sum_r & {SumW{!(pts_r < PtsW'(MaxPathPts))}};
    if (state_r == S_OUT) begin
      out_min_distance   <= (count_r == '0) ? 32'd0 : dist_r;
      out_mean_clearance <= !last_r ? 32'd0 :
                            (quo_r[SumW-1:32] != '0) ? 32'hFFFF_FFFF : quo_r[31:0];
      out_is_last        <= last_r;
      out_no_obstacle    <= (count_r == '0);
      out_store_overflow <= dropped_r;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !(state_r == S_IDLE && $past(state_r) == S_IDLE)) else $error("busy glitch");
  a_valid_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |=> out_valid) else $error("lost result");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MaxObstacles)) else $error("count overrun");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MX) |-> (k_r < count_r)) else $error("walk past fill");
endmodule
`default_nettype wire
